// File: src/brcs_pkg.sv
// ----------------------------------------------------------------------------
// brcs_pkg: shared types and helpers for the control-flow sequencer
// instruction kinds, condition codes, micro step values and the
// condition evaluation function
// ----------------------------------------------------------------------------
package brcs_pkg;

  typedef enum logic [2:0] {
    KIND_JP    = 3'd0,
    KIND_JP_HL = 3'd1,
    KIND_JR    = 3'd2,
    KIND_CALL  = 3'd3,
    KIND_RET   = 3'd4,
    KIND_RETI  = 3'd5,
    KIND_RST   = 3'd6,
    KIND_NONE  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_NZ     = 3'd1,
    COND_Z      = 3'd2,
    COND_NC     = 3'd3,
    COND_C      = 3'd4
  } cond_t;

  localparam logic [2:0] STEP_0 = 3'd0;
  localparam logic [2:0] STEP_1 = 3'd1;
  localparam logic [2:0] STEP_2 = 3'd2;
  localparam logic [2:0] STEP_3 = 3'd3;
  localparam logic [2:0] STEP_4 = 3'd4;

  // unknown condition codes behave as always
  function automatic logic eval_cond(logic [2:0] code, logic z, logic c);
    logic r;
    case (code)
      COND_NZ: r = ~z;
      COND_Z:  r = z;
      COND_NC: r = ~c;
      COND_C:  r = c;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: src/branch_call_return_sequencer.sv
// ----------------------------------------------------------------------------
// branch_call_return_sequencer: machine-cycle sequencer for control flow
// walks jp, jp hl, jr, call, ret, reti and rst through their machine
// cycles, one request per machine cycle, with at most one stack access each
// ----------------------------------------------------------------------------
// Each request is one machine cycle of the current instruction. A request is
// captured into an input register, evaluated against the sequencer state
// (micro step, latched condition, pop word) in combinational logic and written
// to the result register, so the block takes a new request every clock while
// the result register is free or being taken. The input register and the
// result register each move whenever the stage after them is empty or being
// drained, so a waiting result still lets a request into an empty input
// register. The sequencer state is updated when a request leaves the input
// register, which keeps the next request's evaluation in order with it.
// Pushes predecrement SP and write the PC high byte before the low byte;
// pops read the low byte first and post-increment SP. bus_address and
// bus_data are zero on cycles without a write.
module branch_call_return_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  cond,
  input  logic        flag_z,
  input  logic        flag_c,
  input  logic [15:0] imm_word,
  input  logic signed [7:0] rel_offset,
  input  logic [15:0] hl_value,
  input  logic [15:0] pc_in,
  input  logic [15:0] sp_in,
  input  logic [5:0]  rst_vector,
  input  logic [7:0]  mem_at_sp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        bus_write,
  output logic [15:0] bus_address,
  output logic [7:0]  bus_data,
  output logic [15:0] pc_out,
  output logic [15:0] sp_out,
  output logic        done_res,
  output logic        ime_enable
);
  import brcs_pkg::*;

  // input register
  logic        req_valid;
  kind_t       req_kind;
  logic [2:0]  req_cond;
  logic        req_z;
  logic        req_c;
  logic [15:0] req_imm;
  logic [7:0]  req_rel;
  logic [15:0] req_hl;
  logic [15:0] req_pc;
  logic [15:0] req_sp;
  logic [5:0]  req_vec;
  logic [7:0]  req_mem;

  // sequencer state
  logic [2:0]  micro_step;
  logic        cond_taken;
  logic [15:0] pop_latch;
  logic [2:0]  micro_step_next;
  logic        cond_taken_next;
  logic [15:0] pop_latch_next;

  // result of the current request
  logic        res_wr;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic [15:0] res_pc;
  logic [15:0] res_sp;
  logic        res_done;
  logic        res_ime;

  logic        advance;
  logic [15:0] sp_dec;
  logic [15:0] sp_inc;
  logic [15:0] rel_ext;
  logic        cond_eval;

  // the input register drains when the result register is free or being taken
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind <= kind_t'(kind);
      req_cond <= cond;
      req_z    <= flag_z;
      req_c    <= flag_c;
      req_imm  <= imm_word;
      req_rel  <= rel_offset;
      req_hl   <= hl_value;
      req_pc   <= pc_in;
      req_sp   <= sp_in;
      req_vec  <= rst_vector;
      req_mem  <= mem_at_sp;
    end
  end

  assign sp_dec    = req_sp - 16'd1;
  assign sp_inc    = req_sp + 16'd1;
  assign rel_ext   = {{8{req_rel[7]}}, req_rel};
  assign cond_eval = eval_cond(req_cond, req_z, req_c);

  // one machine cycle of the selected instruction
  always_comb begin
    micro_step_next = micro_step;
    cond_taken_next = cond_taken;
    pop_latch_next  = pop_latch;
    res_wr   = 1'b0;
    res_addr = 16'd0;
    res_data = 8'd0;
    res_pc   = req_pc;
    res_sp   = req_sp;
    res_done = 1'b0;
    res_ime  = 1'b0;
    case (req_kind)
      KIND_JP, KIND_JR: begin
        if (micro_step == STEP_0) begin
          cond_taken_next = cond_eval;
          micro_step_next = STEP_1;
        end else if (!cond_taken) begin
          res_done = 1'b1;
        end else if (micro_step == STEP_1) begin
          micro_step_next = STEP_2;
        end else begin
          res_pc   = (req_kind == KIND_JP) ? req_imm : req_pc + rel_ext;
          res_done = 1'b1;
        end
      end
      KIND_JP_HL: begin
        if (micro_step == STEP_0) begin
          micro_step_next = STEP_1;
        end else begin
          res_pc   = req_hl;
          res_done = 1'b1;
        end
      end
      KIND_CALL: begin
        if (micro_step == STEP_0) begin
          cond_taken_next = cond_eval;
          micro_step_next = STEP_1;
        end else if (!cond_taken) begin
          res_done = 1'b1;
        end else if (micro_step == STEP_1) begin
          micro_step_next = STEP_2;
        end else if (micro_step == STEP_2) begin
          res_sp   = sp_dec;
          res_wr   = 1'b1;
          res_addr = sp_dec;
          res_data = req_pc[15:8];
          micro_step_next = STEP_3;
        end else if (micro_step == STEP_3) begin
          res_sp   = sp_dec;
          res_wr   = 1'b1;
          res_addr = sp_dec;
          res_data = req_pc[7:0];
          micro_step_next = STEP_4;
        end else begin
          res_pc   = req_imm;
          res_done = 1'b1;
        end
      end
      KIND_RET, KIND_RETI: begin
        if (micro_step == STEP_0) begin
          // reti is unconditional
          cond_taken_next = (req_kind == KIND_RET) ? cond_eval : 1'b1;
          micro_step_next = STEP_1;
        end else if (req_kind == KIND_RET && !cond_taken) begin
          res_done = 1'b1;
        end else if (micro_step == STEP_1) begin
          micro_step_next = STEP_2;
        end else if (micro_step == STEP_2) begin
          pop_latch_next  = {8'd0, req_mem};
          res_sp          = sp_inc;
          micro_step_next = STEP_3;
        end else if (micro_step == STEP_3) begin
          // high byte merged into the latch as the bus read does
          pop_latch_next  = pop_latch | {req_mem, 8'd0};
          res_sp          = sp_inc;
          micro_step_next = STEP_4;
        end else begin
          res_pc   = pop_latch;
          res_ime  = (req_kind == KIND_RETI);
          res_done = 1'b1;
        end
      end
      KIND_RST: begin
        if (micro_step == STEP_0) begin
          micro_step_next = STEP_1;
        end else if (micro_step == STEP_1) begin
          res_sp   = sp_dec;
          res_wr   = 1'b1;
          res_addr = sp_dec;
          res_data = req_pc[15:8];
          micro_step_next = STEP_2;
        end else if (micro_step == STEP_2) begin
          res_sp   = sp_dec;
          res_wr   = 1'b1;
          res_addr = sp_dec;
          res_data = req_pc[7:0];
          micro_step_next = STEP_3;
        end else begin
          res_pc   = {10'd0, req_vec};
          res_done = 1'b1;
        end
      end
      default: begin
        // unused kind finishes at once with no effect
        res_done = 1'b1;
      end
    endcase
    if (res_done) begin
      micro_step_next = STEP_0;
    end
  end

  // state moves only when a request is retired into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      micro_step <= STEP_0;
      cond_taken <= 1'b0;
      pop_latch  <= 16'd0;
    end else if (advance) begin
      micro_step <= micro_step_next;
      cond_taken <= cond_taken_next;
      pop_latch  <= pop_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bus_write   <= res_wr;
      bus_address <= res_addr;
      bus_data    <= res_data;
      pc_out      <= res_pc;
      sp_out      <= res_sp;
      done_res    <= res_done;
      ime_enable  <= res_ime;
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    micro_step <= STEP_4)
    else $error("micro step out of range");

  a_done_clears_step: assert property (@(posedge clk) disable iff (rst)
    advance && res_done |=> micro_step == STEP_0)
    else $error("micro step not cleared after finish");

  a_ime_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && ime_enable |-> done_res && !bus_write)
    else $error("interrupt enable outside a finishing cycle");

  a_write_addr_is_sp: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_write |-> !done_res && bus_address == sp_out)
    else $error("stack write address differs from new sp");

  a_stalled_req_holds: assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=> req_valid && $stable(req_pc) && $stable(req_kind))
    else $error("stalled request lost");

endmodule
